// ===== hw/rtl/bced_pkg.sv =====
package bced_pkg;

	localparam int KEYS_DEF   = 8;
	localparam int FIFO_DEPTH = 4;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DEBOUNCE,
		PH_PRESSED,
		PH_RELEASED
	} phase_t;

	typedef enum logic [1:0] {
		EV_PRESSED,
		EV_LONG,
		EV_CLICK,
		EV_MULTI
	} evt_kind_t;

	typedef enum logic [2:0] {
		CFG_DEBOUNCE,
		CFG_LONG_PRESS,
		CFG_MULTI_CLICK,
		CFG_IDLE_LEVELS,
		CFG_DELAY_EN,
		CFG_ACTIVE_KEYS
	} cfg_reg_t;

	// per-button state word
	typedef struct packed {
		phase_t      phase;
		logic [3:0]  sent;          // bit per evt_kind_t already sent this press
		logic [31:0] change_time;
		logic [31:0] release_time;
		logic [7:0]  streak;
		logic        prior_level;
		logic        click_pending;
	} key_state_t;

	localparam key_state_t KEY_STATE_RST = '{
		phase:         PH_IDLE,
		sent:          4'h0,
		change_time:   32'h0,
		release_time:  32'h0,
		streak:        8'h0,
		prior_level:   1'b1,
		click_pending: 1'b0
	};

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [15:0] long_press_ms;
		logic [15:0] multi_win_ms;
	} timing_cfg_t;

	// events raised by one poll, up to two
	typedef struct packed {
		logic [2:0] button;
		logic       two_evt;
		evt_kind_t  kind0;
		logic [7:0] streak0;
		evt_kind_t  kind1;
		logic [7:0] streak1;
	} evt_pair_t;

endpackage

// ===== hw/rtl/button_click_event_detector.sv =====
// Button click event detector.
// Slave stream (s_*) carries one poll per transaction: button index, sampled
// pin level and the free-running millisecond time. Master stream (m_*) carries
// events: pressed, long pressed, click, multi click, with the button's
// multi-click streak; m_tlast marks the final event raised by a poll.
// Polls that raise no event produce nothing; polls of buttons at or above
// active_keys are dropped.
// Config channel (cfg_*) writes one register per transaction; write only while
// the block is idle. cfg_ready is always high.
// Order: a poll's state word is read from memory as the poll is taken; the
// update and the event queue write follow, and its first event then shows on m_*.
// Throughput: one poll per cycle while s_tready is high; the state memory reads
// one entry and writes one each cycle, and a back-to-back poll of the same
// button is served by a one-entry forward of the last write. The output moves
// one event per cycle while m_tready is high; a two-event poll takes two beats.
// Stall: the 4-entry event queue absorbs results; s_tready drops when queue
// entries plus the poll in flight would leave no room.
// Reset: registers take their defaults; all button state reads as idle through
// per-entry valid bits, so no clearing pass is needed.
module button_click_event_detector #(
	parameter int KEYS = bced_pkg::KEYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,    // key_index[2:0], pin_level[3], now_ms[35:4], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // button[2:0], click_streak[10:3], zero pad
	output logic [1:0]  m_tuser,    // event_kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import bced_pkg::*;

	localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	// config registers
	timing_cfg_t tcfg_q;
	logic [7:0]  idle_lv_q;
	logic [7:0]  dly_en_q;
	logic [3:0]  act_keys_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcfg_q.debounce_ms    <= 16'd50;
			tcfg_q.long_press_ms  <= 16'd1000;
			tcfg_q.multi_win_ms   <= 16'd300;
			idle_lv_q             <= 8'hFF;
			dly_en_q              <= 8'h00;
			act_keys_q            <= 4'h0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DEBOUNCE:    tcfg_q.debounce_ms    <= cfg_data;
				CFG_LONG_PRESS:  tcfg_q.long_press_ms  <= cfg_data;
				CFG_MULTI_CLICK: tcfg_q.multi_win_ms   <= cfg_data;
				CFG_IDLE_LEVELS: idle_lv_q             <= cfg_data[7:0];
				CFG_DELAY_EN:    dly_en_q              <= cfg_data[7:0];
				CFG_ACTIVE_KEYS: act_keys_q            <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// input side
	logic [2:0]  in_key;
	logic        in_acc, in_active, go;
	logic [CW-1:0] fifo_cnt;

	assign in_key    = s_tdata[2:0];
	assign in_acc    = s_tvalid && s_tready;
	assign in_active = ({1'b0, in_key} < act_keys_q) && (int'(in_key) < KEYS);
	assign go        = in_acc && in_active;

	// s1: state word arrives from memory
	logic          v_s1;
	logic [2:0]    key_s1;
	logic          lvl_s1;
	logic [31:0]   now_s1;
	logic [KW-1:0] addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			key_s1 <= in_key;
			lvl_s1 <= s_tdata[3];
			now_s1 <= s_tdata[35:4];
		end
	end

	assign addr_s1 = KW'(key_s1);

	// room for the poll in flight and the one being taken
	assign s_tready = (int'(fifo_cnt) + int'(v_s1)) < FIFO_DEPTH;

	key_state_t mem_rd, cur, nxt, byp_q;
	logic          byp_v_q;
	logic [KW-1:0] byp_addr_q;
	evt_pair_t     evts;
	logic          has_evt;

	bced_state_mem #(
		.KEYS (KEYS),
		.KW   (KW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (go),
		.rd_addr (KW'(in_key)),
		.rd_data (mem_rd),
		.wr_en   (v_s1),
		.wr_addr (addr_s1),
		.wr_data (nxt)
	);

	// write of the previous poll lands on the same edge as this poll's read
	assign cur = (byp_v_q && (byp_addr_q == addr_s1)) ? byp_q : mem_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_v_q <= 1'b0;
		end else begin
			byp_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			byp_addr_q <= addr_s1;
			byp_q      <= nxt;
		end
	end

	bced_poll_logic u_poll (
		.cur      (cur),
		.key      (key_s1),
		.lvl      (lvl_s1),
		.now      (now_s1),
		.idle_lvl (idle_lv_q[key_s1]),
		.dly      (dly_en_q[key_s1]),
		.tcfg     (tcfg_q),
		.nxt      (nxt),
		.evts     (evts),
		.has_evt  (has_evt)
	);

	bced_evt_fifo #(
		.DEPTH (FIFO_DEPTH),
		.CW    (CW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s1 && has_evt),
		.push_data (evts),
		.cnt       (fifo_cnt),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	a_room_for_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> int'(fifo_cnt) < FIFO_DEPTH)
		else $error("poll in update stage with no queue room");

	a_drop_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !in_active |=> !v_s1)
		else $error("inactive button poll entered update stage");

	a_fwd_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> byp_v_q && (byp_addr_q == $past(addr_s1)))
		else $error("forward register missed a state write");

endmodule

// ===== hw/rtl/bced_state_mem.sv =====
module bced_state_mem #(
	parameter int KEYS = bced_pkg::KEYS_DEF,
	parameter int KW   = (KEYS > 1) ? $clog2(KEYS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [KW-1:0]        rd_addr,
	output bced_pkg::key_state_t rd_data,
	input  logic                 wr_en,
	input  logic [KW-1:0]        wr_addr,
	input  bced_pkg::key_state_t wr_data
);
	import bced_pkg::*;

	key_state_t            mem_q [KEYS];
	key_state_t            rdata_q;
	logic       [KEYS-1:0] vld_q;
	logic                  rvld_q;

	// read-before-write on a same-entry collision; caller forwards
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	// never-written entry reads as reset state
	assign rd_data = rvld_q ? rdata_q : KEY_STATE_RST;

endmodule

// ===== hw/rtl/bced_poll_logic.sv =====
module bced_poll_logic (
	input  bced_pkg::key_state_t  cur,
	input  logic [2:0]            key,
	input  logic                  lvl,
	input  logic [31:0]           now,
	input  logic                  idle_lvl,
	input  logic                  dly,
	input  bced_pkg::timing_cfg_t tcfg,
	output bced_pkg::key_state_t  nxt,
	output bced_pkg::evt_pair_t   evts,
	output logic                  has_evt
);
	import bced_pkg::*;

	function automatic logic [3:0] kind_bit(input evt_kind_t k);
		return 4'b0001 << k;
	endfunction

	function automatic logic can_send(input logic [3:0] sent, input evt_kind_t k,
	                                  input logic [1:0] n);
		logic long_blk;
		long_blk = sent[EV_LONG] && ((k == EV_CLICK) || (k == EV_MULTI));
		return ((sent & kind_bit(k)) == 4'h0) && !long_blk && (n != 2'd2);
	endfunction

	function automatic evt_pair_t put_evt(input evt_pair_t p, input logic [1:0] n,
	                                      input evt_kind_t k, input logic [7:0] s);
		evt_pair_t r;
		r = p;
		if (n == 2'd0) begin
			r.kind0   = k;
			r.streak0 = s;
		end else begin
			r.kind1   = k;
			r.streak1 = s;
			r.two_evt = 1'b1;
		end
		return r;
	endfunction

	key_state_t  s;
	evt_pair_t   ev;
	logic [1:0]  n;
	logic [31:0] d_rt, d_ct, dct_deb, dct_pr, d_rel;
	logic [16:0] lp_db;
	logic        pend_fire, enter_deb, enter_pr, lvl_chg;

	always_comb begin
		s          = cur;
		ev         = '0;
		ev.button  = key;
		n          = 2'd0;
		lvl_chg    = cur.prior_level != lvl;
		d_rt       = now - cur.release_time;
		d_ct       = now - cur.change_time;
		lp_db      = {1'b0, tcfg.long_press_ms} + {1'b0, tcfg.debounce_ms};
		pend_fire  = cur.click_pending && (d_rt > {16'h0, tcfg.multi_win_ms});

		// held-back single click whose window has closed
		if (pend_fire) begin
			ev              = put_evt(ev, n, EV_CLICK, s.streak);
			n               = n + 2'd1;
			s.click_pending = 1'b0;
			s.release_time  = now;
		end

		enter_deb = (cur.phase == PH_IDLE) && !(!lvl_chg && (lvl == idle_lvl));
		if (enter_deb) begin
			s.sent  = 4'h0;
			s.phase = PH_DEBOUNCE;
		end

		enter_pr = 1'b0;
		dct_deb  = lvl_chg ? 32'h0 : d_ct;
		if (enter_deb || (cur.phase == PH_DEBOUNCE)) begin
			if (lvl_chg) begin
				s.change_time = now;
			end
			if (dct_deb >= {16'h0, tcfg.debounce_ms}) begin
				if (lvl == idle_lvl) begin
					s.phase = PH_RELEASED;
				end else begin
					s.phase  = PH_PRESSED;
					enter_pr = 1'b1;
				end
			end
		end

		dct_pr = enter_pr ? dct_deb : d_ct;
		if (enter_pr || (cur.phase == PH_PRESSED)) begin
			if (lvl == idle_lvl) begin
				s.phase = PH_DEBOUNCE;
				// delay mode: press reported on release unless it went long
				if (dly && !s.sent[EV_LONG] && can_send(s.sent, EV_PRESSED, n)) begin
					ev     = put_evt(ev, n, EV_PRESSED, s.streak);
					n      = n + 2'd1;
					s.sent = s.sent | kind_bit(EV_PRESSED);
				end
			end else begin
				if (!dly && can_send(s.sent, EV_PRESSED, n)) begin
					ev     = put_evt(ev, n, EV_PRESSED, s.streak);
					n      = n + 2'd1;
					s.sent = s.sent | kind_bit(EV_PRESSED);
				end
				// restart of hold timer happens even when the event is masked
				if ((n != 2'd2) && (dct_pr >= {15'h0, lp_db})) begin
					if (can_send(s.sent, EV_LONG, n)) begin
						ev     = put_evt(ev, n, EV_LONG, s.streak);
						n      = n + 2'd1;
						s.sent = s.sent | kind_bit(EV_LONG);
					end
					s.change_time = now;
				end
			end
		end

		d_rel = pend_fire ? 32'h0 : d_rt;
		if (cur.phase == PH_RELEASED) begin
			if (d_rel <= {16'h0, tcfg.multi_win_ms}) begin
				if (s.streak != 8'hFF) begin
					s.streak = s.streak + 8'd1;
				end
				if (can_send(s.sent, EV_MULTI, n)) begin
					ev     = put_evt(ev, n, EV_MULTI, s.streak);
					n      = n + 2'd1;
					s.sent = s.sent | kind_bit(EV_MULTI);
				end
				s.click_pending = 1'b0;
			end else begin
				s.streak = 8'h0;
				if (dly && !s.sent[EV_LONG]) begin
					s.click_pending = 1'b1;
				end else if (can_send(s.sent, EV_CLICK, n)) begin
					ev     = put_evt(ev, n, EV_CLICK, s.streak);
					n      = n + 2'd1;
					s.sent = s.sent | kind_bit(EV_CLICK);
				end
			end
			s.release_time = now;
			s.phase        = PH_IDLE;
		end

		s.prior_level = lvl;
	end

	assign nxt     = s;
	assign evts    = ev;
	assign has_evt = n != 2'd0;

endmodule

// ===== hw/rtl/bced_evt_fifo.sv =====
module bced_evt_fifo #(
	parameter int DEPTH = bced_pkg::FIFO_DEPTH,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bced_pkg::evt_pair_t push_data,
	output logic [CW-1:0]       cnt,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata,   // button[2:0], click_streak[10:3], zero pad
	output logic [1:0]          m_tuser,   // event_kind
	output logic                m_tlast
);
	import bced_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	evt_pair_t         fifo_q [DEPTH];
	evt_pair_t         head;
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     cnt_q;
	logic              sel_q;
	logic              pop, beat;
	logic [7:0]        streak_out;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	assign head       = fifo_q[rd_ptr_q];
	assign m_tvalid   = cnt_q != '0;
	assign m_tlast    = sel_q || !head.two_evt;
	assign m_tuser    = sel_q ? head.kind1 : head.kind0;
	assign streak_out = sel_q ? head.streak1 : head.streak0;
	assign m_tdata    = {5'h0, streak_out, head.button};
	assign beat       = m_tvalid && m_tready;
	assign pop        = beat && m_tlast;
	assign cnt        = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			sel_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (beat) begin
				sel_q <= !m_tlast;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("event queue count out of range");

	a_sel_pair: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> (cnt_q != '0) && head.two_evt)
		else $error("second-event select without a two-event entry");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q < CW'(DEPTH))
		else $error("push into full event queue");

endmodule
